// ----- rtl/core/pss_wlh_pkg.sv -----
`default_nettype none

package pss_wlh_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned FW        = 20;
  localparam int unsigned RW        = 31;
  localparam int unsigned MW        = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W    = 5;

  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE_VAL = DW'(64'd1 << FW);
  // 7/60 rounded to nearest at FW fraction bits.
  localparam logic signed [DW-1:0] KP_VAL  = DW'(((64'd14 << FW) + 64'd60) / 64'd120);

  localparam logic [STEP_W-1:0] STEP_PRED_LAST = STEP_W'(24);
  localparam logic [STEP_W-1:0] STEP_CORR_LAST = STEP_W'(27);

  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_PRED = 2'd1,
    REQ_CORR = 2'd2,
    REQ_RSV  = 2'd3
  } req_e;

  typedef enum logic [MW-1:0] {
    MODE_OFF   = 2'd0,
    MODE_LOCAL = 2'd1,
    MODE_WIDE  = 2'd2,
    MODE_RSV   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_GAIN  = 3'd1,
    CFG_WASH  = 3'd2,
    CFG_RAT1  = 3'd3,
    CFG_LAG1  = 3'd4,
    CFG_RAT2  = 3'd5,
    CFG_LAG2  = 3'd6,
    CFG_LIMIT = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_MULH = 3'd4
  } op_e;

  typedef enum logic [4:0] {
    SRC_SPD  = 5'd0,
    SRC_ONE  = 5'd1,
    SRC_KP   = 5'd2,
    SRC_WAF  = 5'd3,
    SRC_W    = 5'd4,
    SRC_T0   = 5'd5,
    SRC_G    = 5'd6,
    SRC_V2   = 5'd7,
    SRC_X0   = 5'd8,
    SRC_X1   = 5'd9,
    SRC_X2   = 5'd10,
    SRC_B0   = 5'd11,
    SRC_B1   = 5'd12,
    SRC_B2   = 5'd13,
    SRC_P0   = 5'd14,
    SRC_P1   = 5'd15,
    SRC_P2   = 5'd16,
    SRC_D0   = 5'd17,
    SRC_D1   = 5'd18,
    SRC_D2   = 5'd19,
    SRC_WASH = 5'd20,
    SRC_GAIN = 5'd21,
    SRC_RAT1 = 5'd22,
    SRC_LAG1 = 5'd23,
    SRC_RAT2 = 5'd24,
    SRC_LAG2 = 5'd25,
    SRC_DT   = 5'd26
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE = 4'd0,
    DST_W    = 4'd1,
    DST_T0   = 4'd2,
    DST_G    = 4'd3,
    DST_V2   = 4'd4,
    DST_V3   = 4'd5,
    DST_D0   = 4'd6,
    DST_D1   = 4'd7,
    DST_D2   = 4'd8,
    DST_N0   = 4'd9,
    DST_N1   = 4'd10,
    DST_N2   = 4'd11,
    DST_COPY = 4'd12
  } dst_e;

  typedef struct packed {
    logic valid;
    logic last;
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
  } uop_t;

endpackage

`default_nettype wire

// ----- rtl/core/pss_wlh_alu.sv -----
`default_nettype none

module pss_wlh_alu import pss_wlh_pkg::*; (
  input  op_e                   op_i,
  input  logic signed [DW-1:0]  a_i,
  input  logic signed [DW-1:0]  b_i,
  output logic signed [DW-1:0]  res_o,
  output logic                  sat_o
);

  localparam int unsigned PW = 2 * DW;
  localparam int unsigned QW = PW - FW;

  logic signed [DW-1:0] a_eff;
  logic signed [PW-1:0] prod;
  logic        [QW-1:0] prod_q;
  logic        [QW-DW:0] prod_top;
  logic                 mul_ovf;
  logic signed [DW:0]   a_ext;
  logic signed [DW:0]   b_ext;
  logic signed [DW:0]   sum;
  logic                 sum_ovf;

  always_comb begin
    a_eff    = (op_i == OP_MULH) ? (a_i >>> 1) : a_i;
    prod     = a_eff * b_i;
    prod_q   = prod[PW-1:FW];
    prod_top = prod_q[QW-1:DW-1];
    mul_ovf  = (|prod_top) && !(&prod_top);
    a_ext    = {a_i[DW-1], a_i};
    b_ext    = {b_i[DW-1], b_i};
    sum      = (op_i == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
    sum_ovf  = sum[DW] != sum[DW-1];
    case (op_i)
      OP_ADD, OP_SUB: begin
        sat_o = sum_ovf;
        res_o = sum_ovf ? (sum[DW] ? VAL_MIN : VAL_MAX) : sum[DW-1:0];
      end
      OP_MUL, OP_MULH: begin
        sat_o = mul_ovf;
        res_o = mul_ovf ? (prod_q[QW-1] ? VAL_MIN : VAL_MAX) : prod_q[DW-1:0];
      end
      default: begin
        sat_o = 1'b0;
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/pss_wlh_seq.sv -----
`default_nettype none

module pss_wlh_seq import pss_wlh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  req_e  req_i,
  input  logic  first_i,
  input  logic  mode_wide_i,
  input  logic  out_stall_i,
  output logic  busy_o,
  output logic  out_load_o,
  output logic  out_valid_o,
  output uop_t  uop_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  req_e                req_q;
  logic                first_q;
  logic                wide_q;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  function automatic uop_t mk(input op_e op, input src_e a, input src_e b, input dst_e d);
    uop_t u;
    u.valid = 1'b1;
    u.last  = 1'b0;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    return u;
  endfunction

  function automatic uop_t prog(input logic [STEP_W-1:0] step, input req_e req,
                                input logic wide, input logic first);
    uop_t u;
    logic corr;
    corr = (req == REQ_CORR);
    u = mk(OP_NOP, SRC_T0, SRC_T0, DST_NONE);
    case (step)
      0: begin
        u = mk(OP_ADD, SRC_SPD, SRC_ONE, DST_W);
        u.last = (req == REQ_INIT);
      end
      1: begin
        u = mk(OP_MUL, SRC_KP, SRC_WAF, DST_T0);
        u.valid = wide;
      end
      2: begin
        u = mk(OP_ADD, SRC_W, SRC_T0, DST_W);
        u.valid = wide;
      end
      3: begin
        u = mk(OP_NOP, SRC_T0, SRC_T0, DST_COPY);
        u.valid = (req == REQ_PRED) && !first;
      end
      4:  u = mk(OP_SUB, SRC_W, SRC_X0, DST_T0);
      5:  u = mk(OP_MUL, SRC_T0, SRC_WASH, DST_D0);
      6:  u = mk(OP_MUL, SRC_GAIN, SRC_D0, DST_G);
      7:  u = mk(OP_MUL, SRC_RAT1, SRC_G, DST_T0);
      8:  u = mk(OP_ADD, SRC_T0, SRC_X1, DST_V2);
      9:  u = mk(OP_MUL, SRC_RAT2, SRC_V2, DST_T0);
      10: u = mk(OP_ADD, SRC_T0, SRC_X2, DST_V3);
      11: u = mk(OP_SUB, SRC_ONE, SRC_RAT1, DST_T0);
      12: u = mk(OP_MUL, SRC_T0, SRC_G, DST_T0);
      13: u = mk(OP_SUB, SRC_T0, SRC_X1, DST_T0);
      14: u = mk(OP_MUL, SRC_T0, SRC_LAG1, DST_D1);
      15: u = mk(OP_SUB, SRC_ONE, SRC_RAT2, DST_T0);
      16: u = mk(OP_MUL, SRC_T0, SRC_V2, DST_T0);
      17: u = mk(OP_SUB, SRC_T0, SRC_X2, DST_T0);
      18: u = mk(OP_MUL, SRC_T0, SRC_LAG2, DST_D2);
      19: u = corr ? mk(OP_ADD, SRC_P0, SRC_D0, DST_T0) : mk(OP_MUL, SRC_D0, SRC_DT, DST_T0);
      20: u = corr ? mk(OP_MULH, SRC_T0, SRC_DT, DST_T0) : mk(OP_ADD, SRC_B0, SRC_T0, DST_N0);
      21: u = corr ? mk(OP_ADD, SRC_B0, SRC_T0, DST_N0) : mk(OP_MUL, SRC_D1, SRC_DT, DST_T0);
      22: u = corr ? mk(OP_ADD, SRC_P1, SRC_D1, DST_T0) : mk(OP_ADD, SRC_B1, SRC_T0, DST_N1);
      23: u = corr ? mk(OP_MULH, SRC_T0, SRC_DT, DST_T0) : mk(OP_MUL, SRC_D2, SRC_DT, DST_T0);
      24: begin
        if (corr) begin
          u = mk(OP_ADD, SRC_B1, SRC_T0, DST_N1);
        end else begin
          u = mk(OP_ADD, SRC_B2, SRC_T0, DST_N2);
          u.last = 1'b1;
        end
      end
      25: u = mk(OP_ADD, SRC_P2, SRC_D2, DST_T0);
      26: u = mk(OP_MULH, SRC_T0, SRC_DT, DST_T0);
      27: begin
        u = mk(OP_ADD, SRC_B2, SRC_T0, DST_N2);
        u.last = 1'b1;
      end
      default: begin
        u.valid = 1'b0;
        u.last  = 1'b1;
      end
    endcase
    return u;
  endfunction

  always_comb begin
    if (state_q == S_RUN) begin
      uop_o = prog(step_q, req_q, wide_q, first_q);
    end else begin
      uop_o = mk(OP_NOP, SRC_T0, SRC_T0, DST_NONE);
      uop_o.valid = 1'b0;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load_o  = (state_q == S_WAIT) && out_free;
  assign out_valid_o = out_valid_q;
  assign busy_o      = state_q != S_IDLE;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_load_o ? 1'b1 : (out_valid_q && out_stall_i);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          step_d  = '0;
          state_d = (req_i == REQ_RSV) ? S_WAIT : S_RUN;
        end
      end
      S_RUN: begin
        if (uop_o.last) begin
          state_d = S_WAIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      req_q       <= REQ_INIT;
      first_q     <= 1'b0;
      wide_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (start_i) begin
        req_q   <= req_i;
        first_q <= first_i;
        wide_q  <= mode_wide_i;
      end
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> !(out_valid_q && out_stall_i))
    else $error("Result register loaded while still held by the receiver.");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && req_i != REQ_RSV) |=> (state_q == S_RUN && step_q == '0))
    else $error("Accepted transaction did not start the sequence at step zero.");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (step_q <= STEP_CORR_LAST))
    else $error("Sequencer step ran past the end of the program.");

  a_uop_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uop_o.valid |-> (state_q == S_RUN))
    else $error("Operation issued outside the running state.");

endmodule

`default_nettype wire

// ----- rtl/core/pss_washout_leadlag_heun.sv -----
// Power system stabiliser: washout and two lead-lag stages, Heun integration.
// Input channel: in_valid_i / in_stall_o with req_type_i, first_step_i,
// speed_dev_i, wide_area_freq_i and time_step_i; a transaction completes when
// in_valid_i is high and in_stall_o is low. Each input transaction yields
// exactly one output transaction on out_valid_o / out_stall_i carrying
// stabilizer_out_o and saturated_o.
// One shared saturating add/subtract/multiply unit runs a fixed sequence of
// operations, one per cycle; the sequence length sets the timing. The next
// input transaction can be taken in the cycle after the result is loaded.
// in_stall_o is high while a transaction is being worked on.
// A finished result sits in an output register; a new input may be taken while
// it waits. If the receiver still stalls when the next result is ready, the
// block holds that result and keeps in_stall_o high until the register frees.
// Reset clears all integrator states and the held output, and loads the
// configuration defaults. Configuration must only be written while idle.
`default_nettype none

module pss_washout_leadlag_heun import pss_wlh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RW-1:0]        cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic                 first_step_i,
  input  logic signed [DW-1:0] speed_dev_i,
  input  logic signed [DW-1:0] wide_area_freq_i,
  input  logic [RW-1:0]        time_step_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DW-1:0] stabilizer_out_o,
  output logic                 saturated_o
);

  mode_e                mode_q;
  logic [RW-1:0]        gain_q, wash_q, rat1_q, lag1_q, rat2_q, lag2_q, limit_q;

  logic signed [DW-1:0] spd_q, waf_q;
  logic [RW-1:0]        dt_q;
  req_e                 req_q;

  logic signed [DW-1:0] w_q, t0_q, g_q, v2_q, v3_q;
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] base_q [3];
  logic signed [DW-1:0] next_q [3];
  logic signed [DW-1:0] pred_q [3];
  logic signed [DW-1:0] held_q;
  logic                 sat_q;
  logic signed [DW-1:0] out_data_q;
  logic                 out_sat_q;

  logic                 start;
  logic                 busy;
  logic                 out_load;
  uop_t                 uop;
  logic signed [DW-1:0] alu_a, alu_b, alu_res;
  logic                 alu_sat;
  logic                 x_next;
  logic signed [DW-1:0] lim, nlim, held_clamp;

  assign start      = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign x_next     = (req_q == REQ_CORR);

  pss_wlh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_e'(req_type_i)),
    .first_i     (first_step_i),
    .mode_wide_i (mode_q == MODE_WIDE),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .out_load_o  (out_load),
    .out_valid_o (out_valid_o),
    .uop_o       (uop)
  );

  function automatic logic signed [DW-1:0] sel(input src_e s);
    logic signed [DW-1:0] v;
    case (s)
      SRC_SPD:  v = spd_q;
      SRC_ONE:  v = ONE_VAL;
      SRC_KP:   v = KP_VAL;
      SRC_WAF:  v = waf_q;
      SRC_W:    v = w_q;
      SRC_T0:   v = t0_q;
      SRC_G:    v = g_q;
      SRC_V2:   v = v2_q;
      SRC_X0:   v = x_next ? next_q[0] : base_q[0];
      SRC_X1:   v = x_next ? next_q[1] : base_q[1];
      SRC_X2:   v = x_next ? next_q[2] : base_q[2];
      SRC_B0:   v = base_q[0];
      SRC_B1:   v = base_q[1];
      SRC_B2:   v = base_q[2];
      SRC_P0:   v = pred_q[0];
      SRC_P1:   v = pred_q[1];
      SRC_P2:   v = pred_q[2];
      SRC_D0:   v = d_q[0];
      SRC_D1:   v = d_q[1];
      SRC_D2:   v = d_q[2];
      SRC_WASH: v = DW'(wash_q);
      SRC_GAIN: v = DW'(gain_q);
      SRC_RAT1: v = DW'(rat1_q);
      SRC_LAG1: v = DW'(lag1_q);
      SRC_RAT2: v = DW'(rat2_q);
      SRC_LAG2: v = DW'(lag2_q);
      SRC_DT:   v = DW'(dt_q);
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    alu_a = sel(uop.src_a);
    alu_b = sel(uop.src_b);
  end

  pss_wlh_alu u_alu (
    .op_i  (uop.op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  always_comb begin
    lim  = DW'(limit_q);
    nlim = -lim;
    if (v3_q < nlim) begin
      held_clamp = nlim;
    end else if (v3_q > lim) begin
      held_clamp = lim;
    end else begin
      held_clamp = v3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LOCAL;
      gain_q  <= RW'(104857600);
      wash_q  <= RW'(104858);
      rat1_q  <= RW'(3495253);
      lag1_q  <= RW'(69905067);
      rat2_q  <= RW'(8388608);
      lag2_q  <= RW'(104857600);
      limit_q <= RW'(209715);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[MW-1:0]);
        CFG_GAIN:  gain_q  <= cfg_wdata_i;
        CFG_WASH:  wash_q  <= cfg_wdata_i;
        CFG_RAT1:  rat1_q  <= cfg_wdata_i;
        CFG_LAG1:  lag1_q  <= cfg_wdata_i;
        CFG_RAT2:  rat2_q  <= cfg_wdata_i;
        CFG_LAG2:  lag2_q  <= cfg_wdata_i;
        CFG_LIMIT: limit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      spd_q <= speed_dev_i;
      waf_q <= wide_area_freq_i;
      dt_q  <= time_step_i;
    end
    if (uop.valid) begin
      case (uop.dst)
        DST_W:   w_q    <= alu_res;
        DST_T0:  t0_q   <= alu_res;
        DST_G:   g_q    <= alu_res;
        DST_V2:  v2_q   <= alu_res;
        DST_V3:  v3_q   <= alu_res;
        DST_D0:  d_q[0] <= alu_res;
        DST_D1:  d_q[1] <= alu_res;
        DST_D2:  d_q[2] <= alu_res;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_data_q <= (mode_q == MODE_OFF) ? '0 : held_q;
      out_sat_q  <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= REQ_INIT;
      sat_q  <= 1'b0;
      held_q <= '0;
      for (int i = 0; i < 3; i++) begin
        base_q[i] <= '0;
        next_q[i] <= '0;
        pred_q[i] <= '0;
      end
    end else begin
      if (start) begin
        req_q <= req_e'(req_type_i);
        sat_q <= 1'b0;
      end
      if (uop.valid) begin
        sat_q <= sat_q || alu_sat;
        case (uop.dst)
          DST_N0:   next_q[0] <= alu_res;
          DST_N1:   next_q[1] <= alu_res;
          DST_N2:   next_q[2] <= alu_res;
          DST_COPY: begin
            for (int i = 0; i < 3; i++) begin
              base_q[i] <= next_q[i];
            end
          end
          default: begin
          end
        endcase
        if (uop.last) begin
          case (req_q)
            REQ_INIT: begin
              base_q[0] <= alu_res;
              next_q[0] <= alu_res;
              for (int i = 1; i < 3; i++) begin
                base_q[i] <= '0;
                next_q[i] <= '0;
              end
              held_q <= '0;
            end
            REQ_PRED: begin
              for (int i = 0; i < 3; i++) begin
                pred_q[i] <= d_q[i];
              end
              held_q <= held_clamp;
            end
            REQ_CORR: begin
              held_q <= held_clamp;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign stabilizer_out_o = out_data_q;
  assign saturated_o      = out_sat_q;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pss_wlh_pkg::*;

  localparam int NUM_REGS = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef logic [RW-1:0] cfg_set_t [NUM_REGS];
  typedef longint trio_t [3];

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 sat;
  } stab_result_t;

  localparam cfg_set_t RESET_CFG = '{31'd1, 31'd104857600, 31'd104858, 31'd3495253,
                                     31'd69905067, 31'd8388608, 31'd104857600, 31'd209715};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [RW-1:0]        cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i = '0;
  logic                 first_step_i = 1'b0;
  logic signed [DW-1:0] speed_dev_i = '0;
  logic signed [DW-1:0] wide_area_freq_i = '0;
  logic [RW-1:0]        time_step_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [DW-1:0] stabilizer_out_o;
  logic                 saturated_o;

  pss_washout_leadlag_heun i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .first_step_i     (first_step_i),
    .speed_dev_i      (speed_dev_i),
    .wide_area_freq_i (wide_area_freq_i),
    .time_step_i      (time_step_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .stabilizer_out_o (stabilizer_out_o),
    .saturated_o      (saturated_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cfg_set_t     cfg_val = RESET_CFG;
  trio_t        base_x = '{0, 0, 0};
  trio_t        next_x = '{0, 0, 0};
  trio_t        slope_pred = '{0, 0, 0};
  longint       held_out = 0;
  bit           sat_seen;
  stab_result_t expected_outputs[$];
  stab_result_t want;
  int           gap_pct = 14;
  int           stall_pct = 14;
  int           error_count = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           cfg_sets = 0;
  int           cycle_count = 0;

  function automatic longint sat32(input longint a);
    if (a > SAT_HI) begin
      sat_seen = 1'b1;
      return SAT_HI;
    end
    if (a < SAT_LO) begin
      sat_seen = 1'b1;
      return SAT_LO;
    end
    return a;
  endfunction

  function automatic longint add_s(input longint a, input longint b);
    return sat32(a + b);
  endfunction

  function automatic longint sub_s(input longint a, input longint b);
    return sat32(a - b);
  endfunction

  // The arithmetic shift of the full product rounds towards minus infinity.
  function automatic longint mul_q(input longint a, input longint b);
    return sat32((a * b) >>> FW);
  endfunction

  function automatic longint reg_q(input cfg_e idx);
    return longint'({1'b0, cfg_val[idx]});
  endfunction

  function automatic longint stage_outputs(input longint w, input trio_t x, output trio_t d);
    longint one, r1, r2, v1, g, v2, v3;
    one = longint'(1) << FW;
    r1 = reg_q(CFG_RAT1);
    r2 = reg_q(CFG_RAT2);
    v1 = mul_q(sub_s(w, x[0]), reg_q(CFG_WASH));
    g = mul_q(reg_q(CFG_GAIN), v1);
    v2 = add_s(mul_q(r1, g), x[1]);
    v3 = add_s(mul_q(r2, v2), x[2]);
    d[0] = v1;
    d[1] = mul_q(sub_s(mul_q(sub_s(one, r1), g), x[1]), reg_q(CFG_LAG1));
    d[2] = mul_q(sub_s(mul_q(sub_s(one, r2), v2), x[2]), reg_q(CFG_LAG2));
    return v3;
  endfunction

  function automatic stab_result_t predict_stabilizer(input req_e req, input bit first,
                                                     input logic signed [DW-1:0] spd,
                                                     input logic signed [DW-1:0] waf,
                                                     input logic [RW-1:0] dt);
    stab_result_t res;
    longint speed, w, dtv, lim, v3;
    trio_t d;
    sat_seen = 1'b0;
    if (req != REQ_RSV) begin
      speed = add_s(longint'(spd), longint'(1) << FW);
      dtv = longint'({1'b0, dt});
      if (req == REQ_INIT) begin
        base_x = '{speed, 0, 0};
        next_x = '{speed, 0, 0};
        held_out = 0;
      end else begin
        w = speed;
        if (cfg_val[CFG_MODE][MW-1:0] == MODE_WIDE) begin
          w = add_s(w, mul_q(longint'(KP_VAL), longint'(waf)));
        end
        if (req == REQ_PRED) begin
          if (!first) base_x = next_x;
          v3 = stage_outputs(w, base_x, d);
          for (int i = 0; i < 3; i++) begin
            slope_pred[i] = d[i];
            next_x[i] = add_s(base_x[i], mul_q(d[i], dtv));
          end
        end else begin
          v3 = stage_outputs(w, next_x, d);
          for (int i = 0; i < 3; i++) begin
            next_x[i] = add_s(base_x[i], mul_q(add_s(slope_pred[i], d[i]) >>> 1, dtv));
          end
        end
        lim = reg_q(CFG_LIMIT);
        if (v3 < -lim) v3 = -lim;
        if (v3 > lim) v3 = lim;
        held_out = v3;
      end
    end
    res.value = (cfg_val[CFG_MODE][MW-1:0] == MODE_OFF) ? '0 : held_out[DW-1:0];
    res.sat = sat_seen;
    return res;
  endfunction

  function automatic logic signed [DW-1:0] rand_signal();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return $urandom_range(104858) - 52429;
    endcase
  endfunction

  function automatic logic [RW-1:0] rand_step();
    case ($urandom_range(9))
      0: return RW'($urandom);
      1: return $urandom_range(1) ? '1 : '0;
      default: return RW'($urandom_range(1, 20972));
    endcase
  endfunction

  function automatic logic [RW-1:0] random_reg(input cfg_e idx);
    if (idx == CFG_MODE) begin
      if ($urandom_range(9) < 2) return RW'($urandom_range(3));
      return $urandom_range(1) ? RW'(MODE_WIDE) : RW'(MODE_LOCAL);
    end
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return RW'($urandom);
      default: return RW'($urandom_range(1, 2 * RESET_CFG[idx]));
    endcase
  endfunction

  task automatic send_request(input req_e req, input bit first, input logic signed [DW-1:0] spd,
                              input logic signed [DW-1:0] waf, input logic [RW-1:0] dt);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    first_step_i <= first;
    speed_dev_i <= spd;
    wide_area_freq_i <= waf;
    time_step_i <= dt;
    do @(posedge clk_i); while (in_stall_o);
    expected_outputs.push_back(predict_stabilizer(req, first, spd, waf, dt));
    items_sent++;
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_outputs.size() != 0 || in_stall_o);
  endtask

  task automatic configure(input cfg_set_t s);
    drain_outputs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_e'(i);
      cfg_wdata_i <= s[i];
      @(posedge clk_i);
      cfg_val[i] = (i == CFG_MODE) ? RW'(s[i][MW-1:0]) : s[i];
    end
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  task automatic run_sequences(input int count);
    int start;
    int steps;
    logic signed [DW-1:0] spd, waf;
    logic [RW-1:0] dt;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) == 0) begin
        send_request(req_e'($urandom_range(3)), 1'($urandom_range(1)), rand_signal(),
                     rand_signal(), rand_step());
      end else begin
        send_request(REQ_INIT, 1'($urandom_range(1)), rand_signal(), rand_signal(),
                     rand_step());
        steps = $urandom_range(1, 20);
        for (int k = 0; k < steps; k++) begin
          spd = rand_signal();
          waf = rand_signal();
          dt = rand_step();
          send_request(REQ_PRED, k == 0, spd, waf, dt);
          if ($urandom_range(19) != 0) begin
            send_request(REQ_CORR, 1'($urandom_range(1)), spd, waf, dt);
          end
        end
      end
    end
  endtask

  task automatic test_directed();
    cfg_set_t s;
    s = RESET_CFG;
    send_request(REQ_INIT, 1'b0, '0, '0, '0);
    send_request(REQ_PRED, 1'b1, 32'sd10486, '0, 31'd10486);
    send_request(REQ_CORR, 1'b0, 32'sd10486, '0, 31'd10486);
    send_request(REQ_PRED, 1'b0, -32'sd20972, VAL_MAX, 31'd10486);
    send_request(REQ_CORR, 1'b1, -32'sd20972, VAL_MIN, 31'd10486);
    send_request(REQ_RSV, 1'b1, VAL_MAX, VAL_MAX, '1);
    send_request(REQ_PRED, 1'b0, VAL_MAX, '0, 31'd1);
    send_request(REQ_CORR, 1'b0, VAL_MIN, '0, '1);
    send_request(REQ_INIT, 1'b1, VAL_MAX, VAL_MIN, '1);
    send_request(REQ_INIT, 1'b0, VAL_MIN, '0, '0);
    send_request(REQ_PRED, 1'b1, '0, '0, '0);
    send_request(REQ_CORR, 1'b0, '0, '0, '0);
    s[CFG_MODE] = RW'(MODE_WIDE);
    configure(s);
    send_request(REQ_INIT, 1'b0, '0, VAL_MAX, '0);
    send_request(REQ_PRED, 1'b1, '0, VAL_MAX, 31'd10486);
    send_request(REQ_CORR, 1'b0, '0, VAL_MIN, 31'd10486);
    send_request(REQ_RSV, 1'b0, '0, '0, '0);
    s[CFG_MODE] = RW'(MODE_OFF);
    configure(s);
    send_request(REQ_PRED, 1'b0, 32'sd52429, '0, 31'd10486);
    send_request(REQ_CORR, 1'b0, 32'sd52429, '0, 31'd10486);
    send_request(REQ_RSV, 1'b0, '0, '0, '0);
    s[CFG_MODE] = RW'(MODE_RSV);
    configure(s);
    send_request(REQ_PRED, 1'b0, 32'sd52429, VAL_MAX, 31'd10486);
    send_request(REQ_CORR, 1'b0, 32'sd52429, VAL_MAX, 31'd10486);
    send_request(REQ_RSV, 1'b1, '0, '0, '0);
  endtask

  task automatic test_config_extremes();
    cfg_set_t s;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < NUM_REGS; i++) s[i] = k[0] ? '1 : '0;
      if (k >= 2) s[CFG_MODE] = k[0] ? RW'(MODE_LOCAL) : RW'(MODE_WIDE);
      configure(s);
      run_sequences(25);
    end
  endtask

  task automatic test_random_settings();
    cfg_set_t s;
    for (int phase = 0; phase < 7; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) s[i] = random_reg(cfg_e'(i));
      configure(s);
      gap_pct = (phase == 3) ? 0 : 14;
      stall_pct = gap_pct;
      if (phase == 5) begin
        run_sequences(110);
        drain_outputs();
        run_sequences(110);
      end else begin
        run_sequences(220);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outputs.size() == 0) begin
        if (error_count < 20) begin
          $display("%0t: result %0d arrived with none outstanding", $time, stabilizer_out_o);
        end
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (stabilizer_out_o !== want.value) begin
          if (error_count < 20) begin
            $display("%0t: stabilizer_out expected %0d, got %0d", $time, want.value,
                     stabilizer_out_o);
          end
          error_count++;
        end
        if (saturated_o !== want.sat) begin
          if (error_count < 20) begin
            $display("%0t: saturated expected %0b, got %0b", $time, want.sat, saturated_o);
          end
          error_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
             expected_outputs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    drain_outputs();
    repeat (64) @(posedge clk_i);
    $display("Covered %0d transactions and %0d results over %0d register settings,",
             items_sent, results_checked, cfg_sets);
    $display("with all request types, all input modes and register extremes.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
